FILE: sv/cssc_pkg.sv
`timescale 1ns / 1ps

package cssc_pkg;

    // Character codes the stages look for.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DEL    = 8'h7F;

    // Width of the count field on the result channel.
    localparam int OUT_COUNT_W = 16;

    // Result queue: one item can produce up to three results.
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;
    localparam int QCNT_W  = 3;
    localparam int MAX_RES = 3;

    typedef struct packed {
        logic [OUT_COUNT_W-1:0] element_count;
        logic                   is_end;
        logic [7:0]             out_byte;
    } result_t;

    // String tracking of one stage: string mode and the previous byte it saw.
    typedef struct packed {
        logic       in_string;
        logic [7:0] prev_byte;
    } qstate_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] in_byte;
        logic       last;
    } item_t;

    // Results of one item, in order, in item[0] .. item[num-1].
    typedef struct packed {
        logic [1:0]        num;
        result_t [MAX_RES-1:0] item;
    } batch_t;

    // Updates the string mode of a stage for byte b.
    function automatic qstate_t quote_step(input qstate_t s, input logic [7:0] b);
        qstate_t r;
        r = s;
        if (b == CH_QUOTE && s.prev_byte != CH_BSLASH) begin
            r.in_string = !s.in_string;
        end
        r.prev_byte = b;
        return r;
    endfunction

endpackage

FILE: sv/cssc_core.sv
`timescale 1ns / 1ps

module cssc_core
    import cssc_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  item_t  item,
    output batch_t batch
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic                  strip_in_string_reg, strip_in_string_next;
    logic                  strip_in_comment_reg, strip_in_comment_next;
    logic [7:0]            strip_prev_reg, strip_prev_next;
    logic                  slash_pending_reg, slash_pending_next;
    logic                  star_armed_reg, star_armed_next;
    logic                  text_ended_reg, text_ended_next;
    qstate_t               space_q_reg, space_q_next;
    qstate_t               count_q_reg, count_q_next;
    logic [COUNT_BITS-1:0] comma_total_reg, comma_total_next;

    // Space stage then count stage for one byte leaving the comment stage.
    // Returns 1 when the byte survives and is to be sent on.
    function automatic logic pass_on(input logic [7:0] b, inout qstate_t sp,
                                     inout qstate_t ct, inout logic [COUNT_BITS-1:0] tot);
        logic ctl;
        logic kept;
        sp   = quote_step(sp, b);
        ctl  = (b == CH_SPACE) || (b < CH_SPACE) || (b == CH_DEL);
        kept = sp.in_string || !ctl;
        if (kept) begin
            ct = quote_step(ct, b);
            if (!ct.in_string && b == CH_COMMA && tot != COUNT_MAX) begin
                tot = tot + 1'b1;
            end
        end
        return kept;
    endfunction

    always_comb begin
        logic [7:0]               c;
        logic [7:0]               prev;
        logic                     skip;
        logic                     finish;
        logic [COUNT_BITS-1:0]    cnt;
        logic [COUNT_BITS+OUT_COUNT_W-1:0] cnt_wide;
        logic [1:0]               n;
        result_t [MAX_RES-1:0]    res;

        strip_in_string_next  = strip_in_string_reg;
        strip_in_comment_next = strip_in_comment_reg;
        strip_prev_next       = strip_prev_reg;
        slash_pending_next    = slash_pending_reg;
        star_armed_next       = star_armed_reg;
        text_ended_next       = text_ended_reg;
        space_q_next          = space_q_reg;
        count_q_next          = count_q_reg;
        comma_total_next      = comma_total_reg;
        c        = item.in_byte;
        prev     = strip_prev_reg;
        skip     = 1'b0;
        finish   = 1'b0;
        cnt      = '0;
        cnt_wide = '0;
        n        = '0;
        res      = '0;

        if (item.valid && !text_ended_reg) begin
            if (c == CH_NUL) begin
                finish = 1'b1;
            end else begin
                strip_prev_next = c;
                if (slash_pending_next) begin
                    slash_pending_next = 1'b0;
                    if (c == CH_SLASH || c == CH_STAR) begin
                        strip_in_comment_next = 1'b1;
                        star_armed_next       = 1'b0;
                        skip                  = 1'b1;
                    end else if (pass_on(CH_SLASH, space_q_next, count_q_next,
                                         comma_total_next)) begin
                        res[n] = '{element_count: '0, is_end: 1'b0, out_byte: CH_SLASH};
                        n      = n + 1'b1;
                    end
                end
                if (!skip && strip_in_comment_next) begin
                    skip = 1'b1;
                    if (c == CH_NL || (star_armed_next && c == CH_SLASH)) begin
                        strip_in_comment_next = 1'b0;
                        star_armed_next       = 1'b0;
                    end else begin
                        star_armed_next = (c == CH_STAR);
                    end
                end
                if (!skip) begin
                    if (c == CH_QUOTE && prev != CH_BSLASH) begin
                        strip_in_string_next = !strip_in_string_next;
                    end
                    if (!strip_in_string_next && c == CH_SLASH) begin
                        slash_pending_next = 1'b1;
                    end else if (pass_on(c, space_q_next, count_q_next,
                                         comma_total_next)) begin
                        res[n] = '{element_count: '0, is_end: 1'b0, out_byte: c};
                        n      = n + 1'b1;
                    end
                end
                finish = item.last;
            end

            if (finish) begin
                // A slash still held at the end is an ordinary byte.
                if (slash_pending_next) begin
                    slash_pending_next = 1'b0;
                    if (pass_on(CH_SLASH, space_q_next, count_q_next, comma_total_next)) begin
                        res[n] = '{element_count: '0, is_end: 1'b0, out_byte: CH_SLASH};
                        n      = n + 1'b1;
                    end
                end
                text_ended_next = 1'b1;
                cnt = (comma_total_next == COUNT_MAX) ? COUNT_MAX
                                                      : comma_total_next + 1'b1;
                cnt_wide = {{OUT_COUNT_W{1'b0}}, cnt};
                res[n] = '{element_count: cnt_wide[OUT_COUNT_W-1:0], is_end: 1'b1,
                           out_byte: CH_NUL};
                n      = n + 1'b1;
            end
        end

        batch.num  = n;
        batch.item = res;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strip_in_string_reg  <= 1'b0;
            strip_in_comment_reg <= 1'b0;
            strip_prev_reg       <= '0;
            slash_pending_reg    <= 1'b0;
            star_armed_reg       <= 1'b0;
            text_ended_reg       <= 1'b0;
            space_q_reg          <= '0;
            count_q_reg          <= '0;
            comma_total_reg      <= '0;
        end else begin
            strip_in_string_reg  <= strip_in_string_next;
            strip_in_comment_reg <= strip_in_comment_next;
            strip_prev_reg       <= strip_prev_next;
            slash_pending_reg    <= slash_pending_next;
            star_armed_reg       <= star_armed_next;
            text_ended_reg       <= text_ended_next;
            space_q_reg          <= space_q_next;
            count_q_reg          <= count_q_next;
            comma_total_reg      <= comma_total_next;
        end
    end

endmodule

FILE: sv/comment_space_strip_comma_count.sv
`timescale 1ns / 1ps

// Comment, whitespace and comma stage chain over a text byte stream.
// Slave channel: one raw text byte per transfer in s_tdata, s_tlast on the
// final byte; a NUL byte also ends the text and is not passed on.
// Master channel: every kept byte as one transfer with m_tlast low, then one
// closing transfer with m_tlast high, byte zero and the saturating element
// count (commas outside strings plus one) in the upper tdata bits.
// Bytes that arrive after the end of a text give nothing until reset.
// A byte's first result passes through the input register, then a four-entry
// result queue, before its transfer.
// Throughput: one byte per cycle while the result queue holds at most one result.
// A byte can release up to three results (a held slash, itself, the closing
// result); the queue drains one per cycle, so a held byte waits and s_tready
// drops while the queue holds more than one result, and the output port sets
// the sustained rate on such bursts.
// When m_tready is low, results collect in the queue and s_tready falls once
// it cannot take a worst-case item; nothing is lost.
// Reset clears all stage state, the count, the input register and the queue.
module comment_space_strip_comma_count
    import cssc_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_byte, [23:8] element_count
    output logic        m_tlast    // is_end
);

    item_t               in_reg, in_next;
    logic                fire;
    item_t               core_item;
    batch_t              batch;
    result_t             q_mem [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   q_cnt_reg, q_cnt_next;
    logic                pop;
    result_t             head;

    // The held item is processed once the queue has room for all its results.
    assign fire     = in_reg.valid && (q_cnt_reg <= QCNT_W'(QDEPTH - MAX_RES));
    assign s_tready = !in_reg.valid || fire;

    always_comb begin
        in_next = in_reg;
        if (fire) begin
            in_next.valid = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            in_next = '{valid: 1'b1, in_byte: s_tdata, last: s_tlast};
        end
    end

    always_comb begin
        core_item       = in_reg;
        core_item.valid = fire;
    end

    cssc_core #(
        .COUNT_BITS(COUNT_BITS)
    ) u_core (
        .aclk   (aclk),
        .aresetn(aresetn),
        .item   (core_item),
        .batch  (batch)
    );

    assign pop  = m_tvalid && m_tready;
    assign head = q_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(batch.num);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        q_cnt_next  = q_cnt_reg + QCNT_W'(batch.num) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < MAX_RES; k++) begin
            if (2'(k) < batch.num) begin
                q_mem[wr_ptr_reg + QPTR_W'(k)] <= batch.item[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_reg     <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            q_cnt_reg  <= '0;
        end else begin
            in_reg     <= in_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            q_cnt_reg  <= q_cnt_next;
        end
    end

    assign m_tvalid = (q_cnt_reg != '0);
    assign m_tdata  = {head.element_count, head.out_byte};
    assign m_tlast  = head.is_end;

`ifndef SYNTH
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_cnt_reg <= QCNT_W'(QDEPTH))
        else $error("result queue count beyond its depth");

    a_end_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[7:0] == 8'h00))
        else $error("closing result carries a nonzero byte");

    a_byte_count_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tdata[23:8] == 16'h0000))
        else $error("byte result carries a nonzero count");

    a_no_result_without_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (!fire && q_cnt_reg == '0) |=> !m_tvalid)
        else $error("result appeared without a processed item");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> (q_cnt_reg == '0 && !in_reg.valid))
        else $error("reset did not clear the input register and queue");
`endif

endmodule

FILE: verif/tb_comment_space_strip_comma_count.sv
`timescale 1ns / 1ps

module tb_comment_space_strip_comma_count
    import cssc_pkg::*;
;

    localparam int CNT_BITS = 16;
    localparam longint unsigned COUNT_MAX = (64'd1 << CNT_BITS) - 1;
    localparam int LONG_HOLD = 80;
    localparam int DRAIN_CYCLES = 12;

    typedef struct {
        logic [7:0] ch;
        logic       lst;
        bit         wait_drain;   // hold this byte back until all output has arrived
    } text_beat_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;    // [7:0] in_byte
    logic        s_tlast = 1'b0;  // last
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // [7:0] out_byte, [23:8] element_count
    logic        m_tlast;         // is_end

    comment_space_strip_comma_count #(
        .COUNT_BITS(CNT_BITS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    text_beat_t text_q[$];
    result_t    strip_out_q[$];

    int predicted_total = 0;
    int drained = 0;
    int mismatch_cnt = 0;
    int queued_cnt = 0;

    // Stage one: comment stripping with a one-byte slash lookahead.
    logic       cm_in_str = 1'b0;
    logic       cm_in_comment = 1'b0;
    logic [7:0] cm_prev = '0;
    logic       slash_held = 1'b0;
    logic       star_seen = 1'b0;
    logic       text_done = 1'b0;
    // Stage two: whitespace removal. Stage three: comma counting.
    logic       ws_in_str = 1'b0;
    logic [7:0] ws_prev = '0;
    logic       cc_in_str = 1'b0;
    logic [7:0] cc_prev = '0;
    longint unsigned comma_cnt = 0;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    task automatic log_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatch_cnt++;
    endtask

    function automatic int idle_len(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    task automatic add_result(input logic [7:0] b, input logic fin,
                              input logic [OUT_COUNT_W-1:0] cnt);
        result_t r;
        r.out_byte = b;
        r.is_end = fin;
        r.element_count = cnt;
        strip_out_q.push_back(r);
        predicted_total++;
    endtask

    // Stages two and three for a byte that survived comment stripping.
    task automatic pass_kept(input logic [7:0] b);
        logic ctl;
        if (b == CH_QUOTE && ws_prev != CH_BSLASH) ws_in_str = !ws_in_str;
        ws_prev = b;
        ctl = (b == CH_SPACE) || (b < 8'd32) || (b == CH_DEL);
        if (ws_in_str || !ctl) begin
            if (b == CH_QUOTE && cc_prev != CH_BSLASH) cc_in_str = !cc_in_str;
            cc_prev = b;
            if (!cc_in_str && b == CH_COMMA && comma_cnt < COUNT_MAX) comma_cnt++;
            add_result(b, 1'b0, '0);
        end
    endtask

    task automatic close_text();
        longint unsigned cnt;
        if (slash_held) begin
            slash_held = 1'b0;
            pass_kept(CH_SLASH);
        end
        text_done = 1'b1;
        cnt = comma_cnt + 1;
        if (cnt > COUNT_MAX) cnt = COUNT_MAX;
        add_result(CH_NUL, 1'b1, cnt[OUT_COUNT_W-1:0]);
    endtask

    task automatic strip_and_count(input logic [7:0] c, input logic lst);
        logic [7:0] prev;
        logic       take;
        if (text_done) return;
        if (c == CH_NUL) begin
            close_text();
            return;
        end
        prev = cm_prev;
        cm_prev = c;
        take = 1'b1;
        if (slash_held) begin
            slash_held = 1'b0;
            if (c == CH_SLASH || c == CH_STAR) begin
                cm_in_comment = 1'b1;
                star_seen = 1'b0;
                take = 1'b0;
            end else begin
                pass_kept(CH_SLASH);
            end
        end
        if (take && cm_in_comment) begin
            if (c == CH_NL || (star_seen && c == CH_SLASH)) begin
                cm_in_comment = 1'b0;
                star_seen = 1'b0;
            end else begin
                star_seen = (c == CH_STAR);
            end
            take = 1'b0;
        end
        if (take) begin
            if (c == CH_QUOTE && prev != CH_BSLASH) cm_in_str = !cm_in_str;
            if (!cm_in_str && c == CH_SLASH) slash_held = 1'b1;
            else pass_kept(c);
        end
        if (lst) close_text();
    endtask

    // Driver: one byte per transfer from the text queue.
    int tx_idle = 0;
    bit tx_steady = 1'b0;
    logic tx_next_valid;
    text_beat_t tx_beat;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tlast <= 1'b0;
            tx_idle = 0;
        end else begin
            tx_next_valid = s_tvalid;
            if (s_tvalid && s_tready) begin
                strip_and_count(s_tdata, s_tlast);
                tx_next_valid = 1'b0;
                if ($urandom_range(0, 24) == 0) tx_steady = !tx_steady;
                tx_idle = idle_len(tx_steady);
            end
            if (!tx_next_valid) begin
                if (tx_idle > 0) begin
                    tx_idle--;
                end else if (text_q.size() > 0 &&
                             !(text_q[0].wait_drain && predicted_total != drained)) begin
                    tx_beat = text_q.pop_front();
                    s_tdata <= tx_beat.ch;
                    s_tlast <= tx_beat.lst;
                    tx_next_valid = 1'b1;
                end
            end
            s_tvalid <= tx_next_valid;
        end
    end

    // Monitor: checks each output transfer and paces m_tready.
    int rx_idle = 0;
    int results_seen = 0;
    bit rx_steady = 1'b0;
    bit long_hold_done = 1'b0;
    result_t rx_want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_idle = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (strip_out_q.size() == 0) begin
                    log_mismatch($sformatf("unexpected output byte %h end %b",
                                           m_tdata[7:0], m_tlast));
                end else begin
                    rx_want = strip_out_q.pop_front();
                    drained <= drained + 1;
                    if (m_tdata[7:0] !== rx_want.out_byte)
                        log_mismatch($sformatf("out_byte %h, want %h",
                                               m_tdata[7:0], rx_want.out_byte));
                    if (m_tlast !== rx_want.is_end)
                        log_mismatch($sformatf("is_end %b, want %b",
                                               m_tlast, rx_want.is_end));
                    if (m_tdata[23:8] !== rx_want.element_count)
                        log_mismatch($sformatf("element_count %0d, want %0d",
                                               m_tdata[23:8], rx_want.element_count));
                end
                if ($urandom_range(0, 24) == 0) rx_steady = !rx_steady;
                rx_idle = idle_len(rx_steady);
                // One long stall so the result queue fills and the input backs up.
                if (!long_hold_done && results_seen >= 20) begin
                    long_hold_done = 1'b1;
                    rx_idle = LONG_HOLD;
                end
            end
            if (rx_idle > 0) begin
                rx_idle--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic push_char(input logic [7:0] c);
        text_beat_t b;
        b.ch = c;
        b.lst = 1'b0;
        b.wait_drain = 1'b0;
        text_q.push_back(b);
        queued_cnt++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_char(s[i]);
    endtask

    // Text-like tokens so the stages spend most of their time in real states.
    task automatic add_token();
        int kind;
        int n;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2: begin
                n = $urandom_range(1, 4);
                repeat (n) begin
                    if ($urandom_range(0, 3) == 0) push_char(8'("0" + $urandom_range(0, 9)));
                    else push_char(8'("a" + $urandom_range(0, 25)));
                end
            end
            3: begin
                push_char(CH_COMMA);
                if ($urandom_range(0, 1)) push_char(CH_SPACE);
            end
            4: begin
                case ($urandom_range(0, 3))
                    0: push_char(CH_SPACE);
                    1: push_char(8'h09);
                    2: push_char(CH_NL);
                    default: push_char(8'h0D);
                endcase
            end
            5: begin
                push_char(CH_QUOTE);
                n = $urandom_range(0, 5);
                repeat (n) begin
                    case ($urandom_range(0, 5))
                        0: push_char(CH_COMMA);
                        1: push_char(CH_SPACE);
                        2: push_char(CH_SLASH);
                        3: begin
                            push_char(CH_BSLASH);
                            push_char(CH_QUOTE);
                        end
                        default: push_char(8'("a" + $urandom_range(0, 25)));
                    endcase
                end
                push_char(CH_QUOTE);
            end
            6: begin
                push_char(CH_SLASH);
                push_char(CH_SLASH);
                n = $urandom_range(0, 4);
                repeat (n) push_char(8'($urandom_range(32, 126)));
                push_char(CH_NL);
            end
            7: begin
                push_char(CH_SLASH);
                push_char(CH_STAR);
                n = $urandom_range(0, 4);
                repeat (n) begin
                    if ($urandom_range(0, 2) == 0) push_char(CH_STAR);
                    else push_char(8'($urandom_range(32, 126)));
                end
                push_char(CH_STAR);
                push_char(CH_SLASH);
            end
            8: begin
                push_char(CH_SLASH);
                push_char(8'($urandom_range(32, 126)));
            end
            default: push_char(8'($urandom_range(1, 255)));
        endcase
    endtask

    text_beat_t tail;

    initial begin
        // Directed: strings with escaped quotes, commas inside and outside,
        // a released slash, both comment forms, and the byte extremes.
        push_text("a, \"b,/ \\\"x\" /y/*q**/e//z\n");
        push_char(CH_QUOTE);
        push_char(8'h01);
        push_char(8'hFF);
        push_char(CH_QUOTE);
        push_char(CH_DEL);
        push_char(8'h80);
        push_char(8'h1F);
        queued_cnt = 0;

        // The sender pauses here until everything predicted so far has come out.
        add_token();
        text_q[text_q.size() - 1].wait_drain = 1'b0;
        text_q[0].wait_drain = 1'b0;
        for (int i = text_q.size() - 1; i >= 0; i--) begin
            if (i > 0 && text_q.size() - queued_cnt == i) text_q[i].wait_drain = 1'b1;
        end
        while (text_q.size() < 125) add_token();

        // How the text ends: last on a plain byte, last on a held slash, or NUL.
        case ($urandom_range(0, 2))
            0: tail.ch = 8'("a" + $urandom_range(0, 25));
            1: tail.ch = CH_SLASH;
            default: tail.ch = CH_NUL;
        endcase
        tail.lst = (tail.ch == CH_NUL) ? 1'($urandom_range(0, 1)) : 1'b1;
        tail.wait_drain = 1'b0;
        text_q.push_back(tail);

        // Bytes after the end must be taken and produce nothing.
        repeat (4) begin
            tail.ch = 8'($urandom_range(0, 255));
            tail.lst = 1'($urandom_range(0, 1));
            text_q.push_back(tail);
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        while (text_q.size() != 0 || s_tvalid) @(negedge aclk);
        while (strip_out_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (mismatch_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
